// ===== src/pmcs_pkg.sv =====
package pmcs_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int unsigned MIN_CHAIN = 2;
  localparam logic [15:0] MAX_VERTICES_RESET = 16'd256;
  localparam int QUEUE_DEPTH = 4;

  localparam logic REG_MAX_VERTICES = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_CHAIN
  } phase_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               chain_end;
  } point_t;

  typedef struct packed {
    logic [1:0]         cnt;
    point_t [2:0]       w;
  } job_t;

endpackage

// ===== src/pmcs_front.sv =====
module pmcs_front #(
  parameter int COUNT_BITS = pmcs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_x,
  input  logic signed [31:0]   in_y,
  input  logic                 in_final,
  input  logic [15:0]          max_vertices,
  input  logic                 q_full,
  output logic                 push,
  output pmcs_pkg::job_t       push_job
);

  localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  pmcs_pkg::phase_t        phase;
  pmcs_pkg::phase_t        phase_next;
  logic signed [31:0]      held_x;
  logic signed [31:0]      held_y;
  logic [2:0]              chain_dir;
  logic [2:0]              chain_dir_next;
  logic [COUNT_BITS-1:0]   chain_len;
  logic [COUNT_BITS-1:0]   chain_len_next;
  logic [COUNT_BITS-1:0]   len_inc;

  logic [LW-1:0]           mv_ext;
  logic [LW-1:0]           cap_ext;
  logic [LW-1:0]           limit;
  logic [2:0]              seg_dir;
  logic                    open_end;
  logic                    cont_end;
  logic                    ends;
  logic                    accept;
  pmcs_pkg::job_t          job;

  assign mv_ext  = LW'(max_vertices);
  assign cap_ext = LW'({COUNT_BITS{1'b1}});

  always_comb begin
    limit = mv_ext;
    if (mv_ext > cap_ext) begin
      limit = cap_ext;
    end
    if (limit < LW'(pmcs_pkg::MIN_CHAIN)) begin
      limit = LW'(pmcs_pkg::MIN_CHAIN);
    end
  end

  // quadrant code: horizontal, south, west
  assign seg_dir  = {held_y == in_y, in_y < held_y, in_x < held_x};
  assign len_inc  = chain_len + 1'b1;
  assign open_end = seg_dir[2] || in_final || (limit == LW'(pmcs_pkg::MIN_CHAIN));
  assign cont_end = in_final || (LW'(len_inc) >= limit);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (job.cnt != 2'd0);
  assign push_job = job;

  always_comb begin
    job            = '0;
    ends           = 1'b0;
    phase_next     = phase;
    chain_dir_next = chain_dir;
    chain_len_next = chain_len;
    unique case (phase)
      pmcs_pkg::PH_START: begin
        job.w[0]       = '{x: held_x, y: held_y, chain_end: 1'b0};
        job.cnt        = 2'd1;
        chain_dir_next = seg_dir;
        if (open_end) begin
          job.w[1] = '{x: in_x, y: in_y, chain_end: 1'b1};
          job.cnt  = 2'd2;
          ends     = 1'b1;
        end else begin
          chain_len_next = COUNT_BITS'(pmcs_pkg::MIN_CHAIN);
          phase_next     = pmcs_pkg::PH_CHAIN;
        end
      end
      pmcs_pkg::PH_CHAIN: begin
        if (seg_dir != chain_dir) begin
          job.w[0]       = '{x: held_x, y: held_y, chain_end: 1'b1};
          job.w[1]       = '{x: held_x, y: held_y, chain_end: 1'b0};
          job.cnt        = 2'd2;
          chain_dir_next = seg_dir;
          if (open_end) begin
            job.w[2] = '{x: in_x, y: in_y, chain_end: 1'b1};
            job.cnt  = 2'd3;
            ends     = 1'b1;
          end else begin
            chain_len_next = COUNT_BITS'(pmcs_pkg::MIN_CHAIN);
          end
        end else begin
          job.w[0] = '{x: held_x, y: held_y, chain_end: 1'b0};
          job.cnt  = 2'd1;
          if (cont_end) begin
            job.w[1] = '{x: in_x, y: in_y, chain_end: 1'b1};
            job.cnt  = 2'd2;
            ends     = 1'b1;
          end else begin
            chain_len_next = len_inc;
          end
        end
      end
      default: begin
        ends = 1'b1;
        if (in_final) begin
          job.w[0] = '{x: in_x, y: in_y, chain_end: 1'b1};
          job.cnt  = 2'd1;
        end
      end
    endcase
    if (ends) begin
      if (in_final) begin
        phase_next     = pmcs_pkg::PH_IDLE;
        chain_len_next = '0;
      end else begin
        phase_next     = pmcs_pkg::PH_START;
        chain_len_next = COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= pmcs_pkg::PH_IDLE;
      held_x    <= '0;
      held_y    <= '0;
      chain_dir <= '0;
      chain_len <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      held_x    <= in_x;
      held_y    <= in_y;
      chain_dir <= chain_dir_next;
      chain_len <= chain_len_next;
    end
  end

endmodule

// ===== src/pmcs_fifo.sv =====
module pmcs_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pmcs_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pmcs_pkg::job_t  pop_job
);

  localparam int DEPTH = pmcs_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  pmcs_pkg::job_t  mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/pmcs_back.sv =====
module pmcs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  pmcs_pkg::job_t      q_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic                out_end
);

  pmcs_pkg::job_t  cur;
  logic            cur_valid;
  logic [1:0]      idx;
  logic            last_word;
  logic            take;
  pmcs_pkg::point_t word;

  assign last_word = (idx + 2'd1 == cur.cnt);
  assign take      = !cur_valid || (out_ready && last_word);
  assign pop       = take && !q_empty;

  assign word      = cur.w[idx];
  assign out_valid = cur_valid;
  assign out_x     = word.x;
  assign out_y     = word.y;
  assign out_end   = word.chain_end;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      cur_valid <= !q_empty;
      idx       <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// ===== src/polyline_monotone_chain_slicer_core.sv =====
// Flow: a vertex's words enter the job queue when the next vertex (or the final vertex
//   itself) is accepted, and reach the m side through the queue and the output register.
// Throughput: one vertex per cycle while each vertex yields at most one word and m_tready is
//   high; the m side moves one word per cycle while m_tready is high.
// Reset: clears the chain phase, the 4-entry job queue and the output stage;
//   max_vertices returns to 256.
module polyline_monotone_chain_slicer_core #(
  parameter int COUNT_BITS = pmcs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // vx[31:0], vy[63:32]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // out_x[31:0], out_y[63:32]
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0]         max_vertices;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  pmcs_pkg::job_t      push_job;
  pmcs_pkg::job_t      pop_job;
  logic signed [31:0]  out_x;
  logic signed [31:0]  out_y;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pmcs_pkg::REG_MAX_VERTICES) ? {16'd0, max_vertices} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_vertices <= pmcs_pkg::MAX_VERTICES_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pmcs_pkg::REG_MAX_VERTICES) begin
      max_vertices <= pwdata[15:0];
    end
  end

  pmcs_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_x         (s_tdata[31:0]),
    .in_y         (s_tdata[63:32]),
    .in_final     (s_tlast),
    .max_vertices (max_vertices),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  pmcs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  pmcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_end   (m_tlast)
  );

  assign m_tdata = {out_y, out_x};

endmodule

// ===== dv/polyline_monotone_chain_slicer_core_test.sv =====
`timescale 1ns / 100ps

module polyline_monotone_chain_slicer_core_test;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] MAX_VERTICES_ADDR = {pmcs_pkg::REG_MAX_VERTICES, 2'b00};
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // vx[31:0], vy[63:32]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // out_x[31:0], out_y[63:32]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  polyline_monotone_chain_slicer_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  pmcs_pkg::point_t chain_words_due[$];

  logic [15:0]        vertex_limit = pmcs_pkg::MAX_VERTICES_RESET;
  pmcs_pkg::phase_t   chain_phase = pmcs_pkg::PH_IDLE;
  logic signed [31:0] held_x = '0;
  logic signed [31:0] held_y = '0;
  logic [2:0]         chain_quadrant = '0;
  logic [15:0]        chain_count = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [2:0] quadrant_of(input logic signed [31:0] ax, ay, bx, by);
    return {ay == by, by < ay, bx < ax};
  endfunction

  function automatic logic [15:0] effective_limit();
    return (vertex_limit < pmcs_pkg::MIN_CHAIN) ? 16'(pmcs_pkg::MIN_CHAIN) : vertex_limit;
  endfunction

  task automatic push_word(input logic signed [31:0] x, y, input logic last);
    pmcs_pkg::point_t w;
    w.x = x;
    w.y = y;
    w.chain_end = last;
    chain_words_due.push_back(w);
  endtask

  task automatic close_chain_at(input logic signed [31:0] x, y, input logic fin);
    push_word(x, y, 1'b1);
    if (fin) begin
      chain_phase = pmcs_pkg::PH_IDLE;
      chain_count = '0;
    end else begin
      held_x = x;
      held_y = y;
      chain_count = 16'd1;
      chain_phase = pmcs_pkg::PH_START;
    end
  endtask

  task automatic open_chain(input logic signed [31:0] x, y, input logic fin);
    push_word(held_x, held_y, 1'b0);
    if (held_y == y) begin
      close_chain_at(x, y, fin);
      return;
    end
    chain_quadrant = quadrant_of(held_x, held_y, x, y);
    chain_count = 16'(pmcs_pkg::MIN_CHAIN);
    if (fin || chain_count >= effective_limit()) begin
      close_chain_at(x, y, fin);
    end else begin
      held_x = x;
      held_y = y;
      chain_phase = pmcs_pkg::PH_CHAIN;
    end
  endtask

  task automatic slice_vertex(input logic signed [31:0] x, y, input logic fin);
    unique case (chain_phase)
      pmcs_pkg::PH_START: begin
        open_chain(x, y, fin);
      end
      pmcs_pkg::PH_CHAIN: begin
        if (quadrant_of(held_x, held_y, x, y) != chain_quadrant) begin
          push_word(held_x, held_y, 1'b1);
          open_chain(x, y, fin);
        end else begin
          push_word(held_x, held_y, 1'b0);
          chain_count = chain_count + 16'd1;
          if (fin || chain_count >= effective_limit()) begin
            close_chain_at(x, y, fin);
          end else begin
            held_x = x;
            held_y = y;
          end
        end
      end
      default: begin
        if (fin) begin
          push_word(x, y, 1'b1);
          chain_phase = pmcs_pkg::PH_IDLE;
          chain_count = '0;
        end else begin
          held_x = x;
          held_y = y;
          chain_count = 16'd1;
          chain_phase = pmcs_pkg::PH_START;
        end
      end
    endcase
  endtask

  task automatic send_vertex(input logic signed [31:0] x, y, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    slice_vertex(x, y, fin);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (chain_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_vertices(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_VERTICES_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    vertex_limit = value[15:0];
  endtask

  task automatic run_random_polylines(input int n_items);
    int sent;
    int len;
    int roll;
    bit noisy;
    bit flat;
    logic [1:0] quad;
    logic signed [31:0] px, py, dx, dy;
    sent = 0;
    while (sent < n_items) begin
      noisy = ($urandom_range(0, 4) == 0);
      len = $urandom_range(1, 14);
      quad = 2'($urandom_range(0, 3));
      px = $urandom;
      py = $urandom;
      for (int k = 0; k < len; k++) begin
        if (k > 0) begin
          if (noisy) begin
            px = $urandom;
            py = $urandom;
          end else begin
            roll = $urandom_range(0, 99);
            flat = (roll < 10);
            if (roll >= 10 && roll < 22) quad = 2'($urandom_range(0, 3));
            dx = $urandom_range(0, 3);
            dy = flat ? 32'sd0 : 32'($urandom_range(1, 4));
            px = quad[0] ? px - dx : px + dx;
            py = quad[1] ? py - dy : py + dy;
          end
        end
        send_vertex(px, py, k == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  task automatic test_lone_vertex_and_flat_segment();
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
    send_vertex(-32'sd5, 32'sd7, 1'b0);
    send_vertex(32'sd10, 32'sd7, 1'b1);
    send_vertex(32'sd0, 32'sd0, 1'b0);
    send_vertex(32'sd1, 32'sd1, 1'b0);
    send_vertex(32'sd2, 32'sd2, 1'b0);
    send_vertex(32'sd5, 32'sd2, 1'b0);
    send_vertex(32'sd6, -32'sd3, 1'b1);
    wait_drained();
  endtask

  task automatic test_quadrants_and_extremes();
    send_vertex(32'sd0, 32'sd0, 1'b0);
    send_vertex(32'sd0, 32'sd1, 1'b0);
    send_vertex(-32'sd1, 32'sd2, 1'b0);
    send_vertex(-32'sd2, 32'sd1, 1'b0);
    send_vertex(-32'sd1, 32'sd0, 1'b0);
    send_vertex(-32'sd1, -32'sd1, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(-32'sd1, 32'sd0, 1'b0);
    send_vertex(32'sd0, -32'sd1, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    wait_drained();
  endtask

  task automatic test_short_chains();
    write_max_vertices(32'd3);
    for (int k = 0; k < 6; k++) send_vertex(32'(k), 32'(k), k == 5);
    wait_drained();
  endtask

  task automatic test_wide_limit_stream();
    write_max_vertices(32'd65535);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_polylines(30);
  endtask

  task automatic test_sender_gaps();
    write_max_vertices(32'($urandom_range(3, 8)));
    send_idle_pct = 69;
    recv_stall_pct = 0;
    run_random_polylines(30);
  endtask

  task automatic test_receiver_stalls();
    write_max_vertices(32'd3);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    run_random_polylines(25);
  endtask

  task automatic test_mixed_idling();
    write_max_vertices(32'(pmcs_pkg::MAX_VERTICES_RESET));
    send_idle_pct = 28;
    recv_stall_pct = 28;
    run_random_polylines(25);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_words
    pmcs_pkg::point_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (chain_words_due.size() == 0) begin
        $error("unexpected word out_x %0d out_y %0d chain_end %0d",
               $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tlast);
        error_count++;
      end else begin
        w = chain_words_due.pop_front();
        if (m_tdata[31:0] !== w.x) begin
          $error("out_x expected %0d actual %0d", w.x, $signed(m_tdata[31:0]));
          error_count++;
        end
        if (m_tdata[63:32] !== w.y) begin
          $error("out_y expected %0d actual %0d", w.y, $signed(m_tdata[63:32]));
          error_count++;
        end
        if (m_tlast !== w.chain_end) begin
          $error("chain_end expected %0d actual %0d", w.chain_end, m_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("polyline_monotone_chain_slicer_core_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lone_vertex_and_flat_segment();
    test_quadrants_and_extremes();
    test_short_chains();
    test_wide_limit_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    if (error_count == 0) begin
      $display("polyline_monotone_chain_slicer_core_test: done, clean");
    end else begin
      $display("polyline_monotone_chain_slicer_core_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pmcs_pkg.sv
src/pmcs_front.sv
src/pmcs_fifo.sv
src/pmcs_back.sv
src/polyline_monotone_chain_slicer_core.sv
dv/polyline_monotone_chain_slicer_core_test.sv
